// File: rtl/core/gb3_pkg.sv
// Shared types and constants for the 3x3 Gaussian blur core.
`timescale 1ns / 1ps

package gb3_pkg;

  localparam int ROW_BITS      = 12;
  localparam int ROWS_CFG_BITS = 13;
  localparam int MAX_ROWS      = 4096;
  localparam int WEIGHT_BITS   = 4;
  localparam int TAPS          = 9;
  localparam int WEIGHT_SHIFT  = 4;
  localparam int KERNEL_BITS   = 36;
  localparam int COLS_RESET    = 640;
  localparam int JOB_DEPTH     = 4;
  localparam int OUT_DEPTH     = 4;
  localparam int CFG_ADDR_BITS = 5;
  localparam int CFG_DATA_BITS = 64;

  localparam logic [KERNEL_BITS-1:0]   KERNEL_RESET = 36'd4850983201;
  localparam logic [ROWS_CFG_BITS-1:0] ROWS_RESET   = 13'd480;

  localparam logic [1:0] REG_COLUMNS = 2'd0;
  localparam logic [1:0] REG_ROWS    = 2'd1;
  localparam logic [1:0] REG_KERNEL  = 2'd2;

  // Result slots of one input pixel, in emission order.
  localparam int EM_ABOVE_LEFT = 0;
  localparam int EM_ABOVE      = 1;
  localparam int EM_LEFT       = 2;
  localparam int EM_HERE       = 3;

  typedef struct packed {
    logic [3:0] emit;
    logic       row_is0;
    logic       row_is1;
    logic       col_is0;
    logic       col_is1;
  } gb3_ctl_t;

endpackage

// File: rtl/core/gb3_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps

module gb3_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wen,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     ren,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (wen) begin
      mem_r[waddr] <= wdata;
    end
    if (ren) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/core/gb3_fifo.sv
// Small register-based queue with an occupancy count.
`timescale 1ns / 1ps

module gb3_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  input  logic [WIDTH-1:0]           wdata,
  input  logic                       pop,
  output logic [WIDTH-1:0]           rdata,
  output logic                       empty,
  output logic                       full,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH+1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r;
  logic [PW-1:0]    rd_ptr_r;
  logic [CW-1:0]    count_r;
  logic             do_push;
  logic             do_pop;

  assign do_push = push && (count_r != CW'(DEPTH));
  assign do_pop  = pop && (count_r != '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH-1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH-1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  assign rdata = mem_r[rd_ptr_r];
  assign empty = (count_r == '0);
  assign full  = (count_r == CW'(DEPTH));
  assign count = count_r;

endmodule

// File: rtl/core/gb3_front.sv
// Front end: accepts pixels, keeps the line stores and window, and issues convolution jobs.
`timescale 1ns / 1ps

module gb3_front
  import gb3_pkg::*;
#(
  parameter int MAX_COLUMNS = 1024,
  parameter int PIXEL_BITS  = 8
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_push,
  input  logic [PIXEL_BITS-1:0]             in_pixel,
  output logic                              in_full,
  input  logic [$clog2(MAX_COLUMNS+1)-1:0]  cols_cfg,
  input  logic [ROWS_CFG_BITS-1:0]          rows_cfg,
  input  logic [$clog2(JOB_DEPTH+1)-1:0]    job_count,
  output logic                              job_push,
  output logic [TAPS*PIXEL_BITS-1:0]        job_pix,
  output logic [ROW_BITS-1:0]               job_row,
  output logic [$clog2(MAX_COLUMNS)-1:0]    job_col,
  output gb3_ctl_t                          job_ctl
);

  localparam int PB  = PIXEL_BITS;
  localparam int CB  = $clog2(MAX_COLUMNS);
  localparam int CW  = $clog2(MAX_COLUMNS+1);
  localparam int JCW = $clog2(JOB_DEPTH+1);

  logic [CB-1:0]       col_r;
  logic [ROW_BITS-1:0] row_r;
  logic                s1_v_r;
  logic                s1_byp_r;
  logic [PB-1:0]       s1_pix_r;
  logic [CB-1:0]       s1_col_r;
  logic [ROW_BITS-1:0] s1_row_r;
  logic                s1_lastc_r;
  logic                s1_lastr_r;
  logic [PB-1:0]       byp_prev_r;
  logic [PB-1:0]       byp_older_r;
  logic [PB-1:0]       win_r [6];

  logic [CW-1:0]            cols_eff;
  logic [CW-1:0]            ncol_m1;
  logic [ROWS_CFG_BITS-1:0] rows_eff;
  logic [ROWS_CFG_BITS-1:0] nrow_m1;
  logic                     last_col;
  logic                     last_row;
  logic                     in_acc;
  logic [PB-1:0]            prev_rd;
  logic [PB-1:0]            older_rd;
  logic [PB-1:0]            prev_val;
  logic [PB-1:0]            older_val;
  logic [PB-1:0]            cur0;
  logic [PB-1:0]            cur1;
  logic                     r_ge1;
  logic                     c_ge1;

  always_comb begin
    if (cols_cfg == '0) begin
      cols_eff = CW'(1);
    end else if (cols_cfg > CW'(MAX_COLUMNS)) begin
      cols_eff = CW'(MAX_COLUMNS);
    end else begin
      cols_eff = cols_cfg;
    end
    if (rows_cfg == '0) begin
      rows_eff = ROWS_CFG_BITS'(1);
    end else if (rows_cfg > ROWS_CFG_BITS'(MAX_ROWS)) begin
      rows_eff = ROWS_CFG_BITS'(MAX_ROWS);
    end else begin
      rows_eff = rows_cfg;
    end
  end

  assign ncol_m1  = cols_eff - 1'b1;
  assign nrow_m1  = rows_eff - 1'b1;
  assign last_col = CW'(col_r) >= ncol_m1;
  assign last_row = ROWS_CFG_BITS'(row_r) >= nrow_m1;

  // A job word from the stage below may still land in the queue.
  assign in_full = ({1'b0, job_count} + (JCW+1)'(s1_v_r)) >= (JCW+1)'(JOB_DEPTH);
  assign in_acc  = in_push && !in_full;

  gb3_ram #(
    .WIDTH(PB),
    .DEPTH(MAX_COLUMNS)
  ) u_prev (
    .clk  (clk),
    .wen  (s1_v_r),
    .waddr(s1_col_r),
    .wdata(s1_pix_r),
    .ren  (in_acc),
    .raddr(col_r),
    .rdata(prev_rd)
  );

  gb3_ram #(
    .WIDTH(PB),
    .DEPTH(MAX_COLUMNS)
  ) u_older (
    .clk  (clk),
    .wen  (s1_v_r),
    .waddr(s1_col_r),
    .wdata(prev_val),
    .ren  (in_acc),
    .raddr(col_r),
    .rdata(older_rd)
  );

  // A read that met a write to the same column takes the written data.
  assign prev_val  = s1_byp_r ? byp_prev_r : prev_rd;
  assign older_val = s1_byp_r ? byp_older_r : older_rd;
  assign r_ge1     = (s1_row_r != '0);
  assign c_ge1     = (s1_col_r != '0);
  assign cur0      = (s1_row_r >= ROW_BITS'(2)) ? older_val : '0;
  assign cur1      = r_ge1 ? prev_val : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r    <= '0;
      row_r    <= '0;
      s1_v_r   <= 1'b0;
      s1_byp_r <= 1'b0;
      for (int i = 0; i < 6; i++) begin
        win_r[i] <= '0;
      end
    end else begin
      s1_v_r <= in_acc;
      if (in_acc) begin
        s1_byp_r <= s1_v_r && (s1_col_r == col_r);
        if (last_col) begin
          col_r <= '0;
          row_r <= last_row ? '0 : row_r + 1'b1;
        end else begin
          col_r <= col_r + 1'b1;
        end
      end
      if (s1_v_r) begin
        win_r[0] <= win_r[3];
        win_r[1] <= win_r[4];
        win_r[2] <= win_r[5];
        win_r[3] <= cur0;
        win_r[4] <= cur1;
        win_r[5] <= s1_pix_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_pix_r   <= in_pixel;
      s1_col_r   <= col_r;
      s1_row_r   <= row_r;
      s1_lastc_r <= last_col;
      s1_lastr_r <= last_row;
    end
    if (s1_v_r) begin
      byp_prev_r  <= s1_pix_r;
      byp_older_r <= prev_val;
    end
  end

  always_comb begin
    job_ctl.emit[EM_ABOVE_LEFT] = r_ge1 && c_ge1;
    job_ctl.emit[EM_ABOVE]      = r_ge1 && s1_lastc_r;
    job_ctl.emit[EM_LEFT]       = s1_lastr_r && c_ge1;
    job_ctl.emit[EM_HERE]       = s1_lastr_r && s1_lastc_r;
    job_ctl.row_is0             = !r_ge1;
    job_ctl.row_is1             = (s1_row_r == ROW_BITS'(1));
    job_ctl.col_is0             = !c_ge1;
    job_ctl.col_is1             = (s1_col_r == CB'(1));
  end

  assign job_push = s1_v_r && (job_ctl.emit != '0);
  assign job_pix  = {s1_pix_r, cur1, cur0, win_r[5], win_r[4], win_r[3],
                     win_r[2], win_r[1], win_r[0]};
  assign job_row  = s1_row_r;
  assign job_col  = s1_col_r;

  a_job_room: assert property (@(posedge clk) disable iff (!rst_n)
    job_push |-> (job_count < JCW'(JOB_DEPTH)))
    else $error("job word pushed into a full queue");

  a_bypass_src: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_v_r && s1_byp_r) |-> $past(s1_v_r))
    else $error("line store bypass without a preceding write");

  a_frame_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && last_col && last_row) |=> (col_r == '0) && (row_r == '0))
    else $error("position did not wrap at the end of the frame");

endmodule

// File: rtl/core/gb3_back.sv
// Back end: expands each job into its results and computes the weighted sums.
`timescale 1ns / 1ps

module gb3_back
  import gb3_pkg::*;
#(
  parameter int MAX_COLUMNS = 1024,
  parameter int PIXEL_BITS  = 8
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic [KERNEL_BITS-1:0]          kernel,
  input  logic                            job_valid,
  input  logic [TAPS*PIXEL_BITS-1:0]      job_pix,
  input  logic [ROW_BITS-1:0]             job_row,
  input  logic [$clog2(MAX_COLUMNS)-1:0]  job_col,
  input  gb3_ctl_t                        job_ctl,
  output logic                            job_pop,
  input  logic [$clog2(OUT_DEPTH+1)-1:0]  out_count,
  output logic                            out_push,
  output logic [PIXEL_BITS-1:0]           out_pix,
  output logic [ROW_BITS-1:0]             out_row,
  output logic [$clog2(MAX_COLUMNS)-1:0]  out_col,
  output logic                            out_last,
  output logic                            out_fend
);

  localparam int PB  = PIXEL_BITS;
  localparam int CB  = $clog2(MAX_COLUMNS);
  localparam int OCW = $clog2(OUT_DEPTH+1);
  localparam int PRW = PB + WEIGHT_BITS;
  localparam int SW  = PB + WEIGHT_BITS + 4;

  logic [3:0]          done_r;
  logic                a_v_r;
  logic [PB-1:0]       a_win_r [TAPS];
  logic [ROW_BITS-1:0] a_row_r;
  logic [CB-1:0]       a_col_r;
  logic                a_last_r;
  logic                a_fend_r;
  logic                b_v_r;
  logic [PRW-1:0]      b_prod_r [TAPS];
  logic [ROW_BITS-1:0] b_row_r;
  logic [CB-1:0]       b_col_r;
  logic                b_last_r;
  logic                b_fend_r;

  logic [3:0]          remaining;
  logic [3:0]          sel;
  logic                is_last;
  logic                room;
  logic                issue;
  logic                lower;
  logic                right;
  logic [1:0]          src [3];
  logic [PB-1:0]       win [TAPS];
  logic [SW-1:0]       sum;
  logic [SW-WEIGHT_SHIFT-1:0] shifted;

  assign remaining = job_ctl.emit & ~done_r;
  assign sel       = remaining & (~remaining + 4'd1);
  assign is_last   = ((remaining & ~sel) == '0);
  assign room      = ({1'b0, out_count} + (OCW+1)'(a_v_r) + (OCW+1)'(b_v_r))
                     < (OCW+1)'(OUT_DEPTH);
  assign issue     = job_valid && (remaining != '0) && room;
  assign job_pop   = issue && is_last;
  assign lower     = sel[EM_LEFT] || sel[EM_HERE];
  assign right     = sel[EM_ABOVE] || sel[EM_HERE];

  // Column sources: 0 is two columns back, 1 the previous column, 2 the current one.
  always_comb begin
    logic [PB-1:0] u0;
    logic [PB-1:0] u1;
    logic [PB-1:0] u2;
    if (right) begin
      src[0] = job_ctl.col_is0 ? 2'd2 : 2'd1;
      src[1] = 2'd2;
    end else begin
      src[0] = job_ctl.col_is1 ? 2'd1 : 2'd0;
      src[1] = 2'd1;
    end
    src[2] = 2'd2;
    for (int j = 0; j < 3; j++) begin
      u0 = job_pix[(int'(src[j]) * 3 + 0) * PB +: PB];
      u1 = job_pix[(int'(src[j]) * 3 + 1) * PB +: PB];
      u2 = job_pix[(int'(src[j]) * 3 + 2) * PB +: PB];
      if (lower) begin
        win[j]     = job_ctl.row_is0 ? u2 : u1;
        win[3 + j] = u2;
        win[6 + j] = u2;
      end else begin
        win[j]     = job_ctl.row_is1 ? u1 : u0;
        win[3 + j] = u1;
        win[6 + j] = u2;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r <= '0;
      a_v_r  <= 1'b0;
      b_v_r  <= 1'b0;
    end else begin
      a_v_r <= issue;
      b_v_r <= a_v_r;
      if (issue) begin
        done_r <= is_last ? '0 : (done_r | sel);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      for (int k = 0; k < TAPS; k++) begin
        a_win_r[k] <= win[k];
      end
      a_row_r  <= lower ? job_row : job_row - 1'b1;
      a_col_r  <= right ? job_col : job_col - 1'b1;
      a_last_r <= is_last;
      a_fend_r <= sel[EM_HERE];
    end
    if (a_v_r) begin
      for (int k = 0; k < TAPS; k++) begin
        b_prod_r[k] <= PRW'(a_win_r[k]) * PRW'(kernel[k*WEIGHT_BITS +: WEIGHT_BITS]);
      end
      b_row_r  <= a_row_r;
      b_col_r  <= a_col_r;
      b_last_r <= a_last_r;
      b_fend_r <= a_fend_r;
    end
  end

  always_comb begin
    sum = '0;
    for (int k = 0; k < TAPS; k++) begin
      sum = sum + SW'(b_prod_r[k]);
    end
  end

  assign shifted  = sum[SW-1:WEIGHT_SHIFT];
  assign out_pix  = (shifted[SW-WEIGHT_SHIFT-1:PB] != '0) ? '1 : shifted[PB-1:0];
  assign out_push = b_v_r;
  assign out_row  = b_row_r;
  assign out_col  = b_col_r;
  assign out_last = b_last_r;
  assign out_fend = b_fend_r;

  a_out_room: assert property (@(posedge clk) disable iff (!rst_n)
    out_push |-> (out_count < OCW'(OUT_DEPTH)))
    else $error("result word pushed into a full queue");

  a_fend_last: assert property (@(posedge clk) disable iff (!rst_n)
    (a_v_r && a_fend_r) |-> a_last_r)
    else $error("frame end not on the last result of its pixel");

endmodule

// File: rtl/core/gaussian_blur_3x3_replicate_core.sv
// Top level of the streaming 3x3 Gaussian blur with replicated borders.
// A pixel's results pass the s1 stage, job queue, back-end stages a and b and output queue.
// Throughput is one pixel per cycle while results are popped, capped at one result per cycle.
// Last-column pixels give up to two results, last-row ones up to four, so input stalls there.
// Reset is synchronous and active low; the line stores are not cleared and need no sweep.
`timescale 1ns / 1ps

module gaussian_blur_3x3_replicate_core
  import gb3_pkg::*;
#(
  parameter int MAX_COLUMNS = 1024,
  parameter int PIXEL_BITS  = 8
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_push,
  input  logic [PIXEL_BITS-1:0]           in_pixel_in,
  output logic                            in_full,
  output logic                            out_empty,
  input  logic                            out_pop,
  output logic [PIXEL_BITS-1:0]           out_pixel_out,
  output logic [ROW_BITS-1:0]             out_row,
  output logic [$clog2(MAX_COLUMNS)-1:0]  out_column,
  output logic                            out_last_of_run,
  output logic                            out_frame_end,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [CFG_ADDR_BITS-1:0]        paddr,
  input  logic [CFG_DATA_BITS-1:0]        pwdata,
  output logic [CFG_DATA_BITS-1:0]        prdata,
  output logic                            pready
);

  localparam int PB  = PIXEL_BITS;
  localparam int CB  = $clog2(MAX_COLUMNS);
  localparam int CW  = $clog2(MAX_COLUMNS+1);
  localparam int JCW = $clog2(JOB_DEPTH+1);
  localparam int OCW = $clog2(OUT_DEPTH+1);
  localparam int JW  = TAPS*PB + ROW_BITS + CB + $bits(gb3_ctl_t);
  localparam int OW  = PB + ROW_BITS + CB + 2;

  logic [CW-1:0]            cols_r;
  logic [ROWS_CFG_BITS-1:0] rows_r;
  logic [KERNEL_BITS-1:0]   kern_r;
  logic                     cfg_wr;
  logic [1:0]               cfg_idx;

  logic                     f_job_push;
  logic [TAPS*PB-1:0]       f_job_pix;
  logic [ROW_BITS-1:0]      f_job_row;
  logic [CB-1:0]            f_job_col;
  gb3_ctl_t                 f_job_ctl;
  logic [JW-1:0]            jq_rdata;
  logic                     jq_empty;
  logic                     jq_full;
  logic [JCW-1:0]           jq_count;
  logic                     b_job_pop;
  logic [TAPS*PB-1:0]       b_job_pix;
  logic [ROW_BITS-1:0]      b_job_row;
  logic [CB-1:0]            b_job_col;
  gb3_ctl_t                 b_job_ctl;

  logic                     r_push;
  logic [PB-1:0]            r_pix;
  logic [ROW_BITS-1:0]      r_row;
  logic [CB-1:0]            r_col;
  logic                     r_last;
  logic                     r_fend;
  logic [OW-1:0]            oq_rdata;
  logic                     oq_full;
  logic [OCW-1:0]           oq_count;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = paddr[4:3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cols_r <= CW'(COLS_RESET);
      rows_r <= ROWS_RESET;
      kern_r <= KERNEL_RESET;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_COLUMNS: cols_r <= pwdata[CW-1:0];
        REG_ROWS:    rows_r <= pwdata[ROWS_CFG_BITS-1:0];
        REG_KERNEL:  kern_r <= pwdata[KERNEL_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_COLUMNS: prdata = CFG_DATA_BITS'(cols_r);
      REG_ROWS:    prdata = CFG_DATA_BITS'(rows_r);
      REG_KERNEL:  prdata = CFG_DATA_BITS'(kern_r);
      default:     prdata = '0;
    endcase
  end

  gb3_front #(
    .MAX_COLUMNS(MAX_COLUMNS),
    .PIXEL_BITS (PIXEL_BITS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_push  (in_push),
    .in_pixel (in_pixel_in),
    .in_full  (in_full),
    .cols_cfg (cols_r),
    .rows_cfg (rows_r),
    .job_count(jq_count),
    .job_push (f_job_push),
    .job_pix  (f_job_pix),
    .job_row  (f_job_row),
    .job_col  (f_job_col),
    .job_ctl  (f_job_ctl)
  );

  gb3_fifo #(
    .WIDTH(JW),
    .DEPTH(JOB_DEPTH)
  ) u_job_q (
    .clk  (clk),
    .rst_n(rst_n),
    .push (f_job_push),
    .wdata({f_job_pix, f_job_row, f_job_col, f_job_ctl}),
    .pop  (b_job_pop),
    .rdata(jq_rdata),
    .empty(jq_empty),
    .full (jq_full),
    .count(jq_count)
  );

  assign {b_job_pix, b_job_row, b_job_col, b_job_ctl} = jq_rdata;

  gb3_back #(
    .MAX_COLUMNS(MAX_COLUMNS),
    .PIXEL_BITS (PIXEL_BITS)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .kernel   (kern_r),
    .job_valid(!jq_empty),
    .job_pix  (b_job_pix),
    .job_row  (b_job_row),
    .job_col  (b_job_col),
    .job_ctl  (b_job_ctl),
    .job_pop  (b_job_pop),
    .out_count(oq_count),
    .out_push (r_push),
    .out_pix  (r_pix),
    .out_row  (r_row),
    .out_col  (r_col),
    .out_last (r_last),
    .out_fend (r_fend)
  );

  gb3_fifo #(
    .WIDTH(OW),
    .DEPTH(OUT_DEPTH)
  ) u_out_q (
    .clk  (clk),
    .rst_n(rst_n),
    .push (r_push),
    .wdata({r_pix, r_row, r_col, r_last, r_fend}),
    .pop  (out_pop),
    .rdata(oq_rdata),
    .empty(out_empty),
    .full (oq_full),
    .count(oq_count)
  );

  assign {out_pixel_out, out_row, out_column, out_last_of_run, out_frame_end} = oq_rdata;

  a_queues_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    !(jq_full && f_job_push) && !(oq_full && r_push))
    else $error("a queue was pushed while full");

endmodule
